>>> hw/rtl/qeg_pkg.sv
// Package for the quadrature encoder generator: item and level types,
// operation and direction codes, and the reset values of the duration registers.
// Has no dependencies.
`timescale 1ns / 1ps

package qeg_pkg;

  localparam int unsigned TickW  = 24;
  localparam int unsigned StepsW = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_TWIST = 2'd1,
    OP_PUSH  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2,
    DIR_RSVD = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    REG_STEP_TICKS       = 2'd0,
    REG_PRESS_TICKS      = 2'd1,
    REG_LONG_PRESS_TICKS = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_idx_t;

  localparam logic [TickW-1:0]  StepTicksReset      = 24'd50000;
  localparam logic [TickW-1:0]  PressTicksReset     = 24'd100000;
  localparam logic [TickW-1:0]  LongPressTicksReset = 24'd3000000;
  localparam logic [StepsW-1:0] StepsPerTwist       = 16'd4;
  localparam logic [StepsW-1:0] StepsMax            = 16'hFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic       dir;
    logic       long_press;
  } item_t;

  typedef struct packed {
    logic a;
    logic b;
    logic button;
    logic busy;
  } levels_t;

  // Phase index to channel levels {A, B}: 00, 10, 11, 01.
  function automatic logic [1:0] gray_code(input logic [1:0] ph);
    logic [1:0] code;
    case (ph)
      2'd0:    code = 2'b00;
      2'd1:    code = 2'b10;
      2'd2:    code = 2'b11;
      default: code = 2'b01;
    endcase
    return code;
  endfunction

  // A zero duration behaves as a single tick.
  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

>>> hw/rtl/qeg_core.sv
// State of the encoder generator: phase, direction, pending steps and the
// two timers, updated once per item. Depends on qeg_pkg.
`timescale 1ns / 1ps

module qeg_core
  import qeg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  item_t            item,
  input  logic [TickW-1:0] step_ticks,
  input  logic [TickW-1:0] press_ticks,
  input  logic [TickW-1:0] long_press_ticks,
  output levels_t          levels_next
);

  logic [1:0]        phase, phase_next;
  dir_t              direction, direction_next;
  logic [StepsW-1:0] steps_left, steps_left_next;
  logic [TickW-1:0]  step_timer, step_timer_next;
  logic [TickW-1:0]  release_timer, release_timer_next;
  logic              button_state, button_state_next;

  logic [StepsW-1:0] steps_dec;
  logic [StepsW:0]   steps_sum;
  dir_t              want;
  logic [1:0]        code;

  assign steps_dec = (steps_left != '0) ? steps_left - StepsW'(1) : steps_left;
  assign steps_sum = {1'b0, steps_left} + {1'b0, StepsPerTwist};
  assign want      = item.dir ? DIR_CCW : DIR_CW;

  always_comb begin
    phase_next         = phase;
    direction_next     = direction;
    steps_left_next    = steps_left;
    step_timer_next    = step_timer;
    release_timer_next = release_timer;
    button_state_next  = button_state;
    case (op_t'(item.op))
      OP_TICK: begin
        if (step_timer != '0) begin
          step_timer_next = step_timer - TickW'(1);
          // The timer runs out on this tick: play one phase step.
          if (step_timer == TickW'(1)) begin
            if (direction == DIR_CW) begin
              phase_next = phase + 2'd1;
            end else if (direction == DIR_CCW) begin
              phase_next = phase - 2'd1;
            end
            steps_left_next = steps_dec;
            if (steps_dec != '0) begin
              step_timer_next = at_least_one(step_ticks);
            end
          end
        end
        if (release_timer != '0) begin
          release_timer_next = release_timer - TickW'(1);
          if (release_timer == TickW'(1)) begin
            button_state_next = 1'b1;
          end
        end
      end
      OP_TWIST: begin
        if (direction == want) begin
          steps_left_next = steps_sum[StepsW] ? StepsMax : steps_sum[StepsW-1:0];
        end else begin
          direction_next  = want;
          steps_left_next = StepsPerTwist;
        end
        step_timer_next = at_least_one(step_ticks);
      end
      OP_PUSH: begin
        button_state_next  = 1'b0;
        release_timer_next = at_least_one(item.long_press ? long_press_ticks : press_ticks);
      end
      default: begin
      end
    endcase
  end

  assign code = gray_code(phase_next);

  always_comb begin
    levels_next.a      = code[1];
    levels_next.b      = code[0];
    levels_next.button = button_state_next;
    levels_next.busy   = (steps_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 2'd0;
      direction     <= DIR_NONE;
      steps_left    <= '0;
      step_timer    <= '0;
      release_timer <= '0;
      button_state  <= 1'b1;
    end else if (update) begin
      phase         <= phase_next;
      direction     <= direction_next;
      steps_left    <= steps_left_next;
      step_timer    <= step_timer_next;
      release_timer <= release_timer_next;
      button_state  <= button_state_next;
    end
  end

endmodule

>>> hw/rtl/quadrature_encoder_generator_unit.sv
// Top level of the quadrature encoder generator: input register, duration
// registers, result register. Depends on qeg_pkg and qeg_core.
//
//   channel  signals                               direction
//   in       in_valid in_ready op dir long_press   into block
//   out      out_valid out_ready out_a out_b        out of block
//            button_level busy_res
//   cfg      cfg_valid cfg_ready cfg_index cfg_data into block
//
// One beat in, one beat out, through the input register, then the result register.
// A new beat can be taken every cycle unless the output stalls. The input register
// feeds the state update directly, so one beat passes the update per cycle when
// not stalled. When out_ready is low the result register holds, the input register
// fills and then in_ready drops. Synchronous reset returns the phase to A=0 B=0,
// releases the button, clears both timers and reloads the duration registers.
`timescale 1ns / 1ps

module quadrature_encoder_generator_unit
  import qeg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       op,
  input  logic             dir,
  input  logic             long_press,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_a,
  output logic             out_b,
  output logic             button_level,
  output logic             busy_res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [TickW-1:0] cfg_data
);

  logic [TickW-1:0] step_ticks;
  logic [TickW-1:0] press_ticks;
  logic [TickW-1:0] long_press_ticks;

  logic    s1_valid;
  item_t   s1_item;
  logic    s1_fire;
  levels_t levels_next;
  levels_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks       <= StepTicksReset;
      press_ticks      <= PressTicksReset;
      long_press_ticks <= LongPressTicksReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_TICKS:       step_ticks       <= cfg_data;
        REG_PRESS_TICKS:      press_ticks      <= cfg_data;
        REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.op         <= op;
      s1_item.dir        <= dir;
      s1_item.long_press <= long_press;
    end
  end

  qeg_core u_core (
    .clk              (clk),
    .rst              (rst),
    .update           (s1_fire),
    .item             (s1_item),
    .step_ticks       (step_ticks),
    .press_ticks      (press_ticks),
    .long_press_ticks (long_press_ticks),
    .levels_next      (levels_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= levels_next;
    end
  end

  assign out_a        = result.a;
  assign out_b        = result.b;
  assign button_level = result.button;
  assign busy_res     = result.busy;

endmodule

>>> dv/quadrature_encoder_generator_unit_tb.sv
// Self-checking testbench for quadrature_encoder_generator_unit: directed and random
// ticks, twists and pushes against a cycle-free model of the encoder state.
// Depends on qeg_pkg and the quadrature_encoder_generator_unit RTL.
`timescale 1ns / 1ps

module quadrature_encoder_generator_unit_tb;
  import qeg_pkg::*;

  localparam int StallLimit = 2000;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic [1:0]       op         = 2'd0;
  logic             dir        = 1'b0;
  logic             long_press = 1'b0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic             out_a;
  logic             out_b;
  logic             button_level;
  logic             busy_res;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index  = 2'd0;
  logic [TickW-1:0] cfg_data   = '0;

  // Encoder model: effective durations (zero already promoted to one tick) and state.
  logic [TickW-1:0]  eff_step;
  logic [TickW-1:0]  eff_press;
  logic [TickW-1:0]  eff_long;
  logic [1:0]        m_phase;
  dir_t              m_dir;
  logic [StepsW-1:0] m_steps;
  logic [TickW-1:0]  m_step_timer;
  logic [TickW-1:0]  m_release_timer;
  logic              m_button;

  levels_t expected_levels[$];
  levels_t want;
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  bit      burst          = 1'b0;

  quadrature_encoder_generator_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .dir          (dir),
    .long_press   (long_press),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_a        (out_a),
    .out_b        (out_b),
    .button_level (button_level),
    .busy_res     (busy_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic got, input logic exp_v);
    if (got !== exp_v) report_mismatch($sformatf("%s got %b expected %b", name, got, exp_v));
  endtask

  // Applies one accepted beat to the model and queues the levels it must produce.
  function automatic void advance_encoder(input op_t code, input logic turn, input logic hold);
    levels_t lv;
    case (code)
      OP_TICK: begin
        if (m_step_timer != '0) begin
          m_step_timer = m_step_timer - TickW'(1);
          if (m_step_timer == '0) begin
            if (m_dir == DIR_CW) m_phase = m_phase + 2'd1;
            else if (m_dir == DIR_CCW) m_phase = m_phase - 2'd1;
            if (m_steps != '0) m_steps = m_steps - StepsW'(1);
            if (m_steps != '0) m_step_timer = eff_step;
          end
        end
        if (m_release_timer != '0) begin
          m_release_timer = m_release_timer - TickW'(1);
          if (m_release_timer == '0) m_button = 1'b1;
        end
      end
      OP_TWIST: begin
        if (m_dir == (turn ? DIR_CCW : DIR_CW)) begin
          if (m_steps > StepsMax - StepsPerTwist) m_steps = StepsMax;
          else m_steps = m_steps + StepsPerTwist;
        end else begin
          m_dir   = turn ? DIR_CCW : DIR_CW;
          m_steps = StepsPerTwist;
        end
        m_step_timer = eff_step;
      end
      OP_PUSH: begin
        m_button        = 1'b0;
        m_release_timer = hold ? eff_long : eff_press;
      end
      default: ;
    endcase
    // Gray walk 00,10,11,01: A is the parity of the phase index, B its upper bit.
    lv.a      = ^m_phase;
    lv.b      = m_phase[1];
    lv.button = m_button;
    lv.busy   = (m_steps != '0);
    expected_levels.push_back(lv);
  endfunction

  task automatic send_item(input op_t code, input logic turn, input logic hold);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code;
    dir        <= turn;
    long_press <= hold;
    do @(posedge clk); while (!in_ready);
    advance_encoder(code, turn, hold);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_beat(input reg_idx_t idx, input logic [TickW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEP_TICKS:       eff_step  = val | TickW'(val == '0);
      REG_PRESS_TICKS:      eff_press = val | TickW'(val == '0);
      REG_LONG_PRESS_TICKS: eff_long  = val | TickW'(val == '0);
      default: ;
    endcase
  endtask

  // Writes all duration registers back to back; cfg_valid stays high across the beats.
  task automatic set_durations(input logic [TickW-1:0] step_val,
                               input logic [TickW-1:0] press_val,
                               input logic [TickW-1:0] long_val,
                               input bit also_unused = 1'b0);
    wait_idle();
    if (also_unused) write_beat(REG_UNUSED, TickW'($urandom));
    write_beat(REG_STEP_TICKS, step_val);
    write_beat(REG_PRESS_TICKS, press_val);
    write_beat(REG_LONG_PRESS_TICKS, long_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_levels();
    send_item(OP_NONE, 1'b1, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b0);
  endtask

  task automatic test_directed_sequence();
    set_durations(24'd2, 24'd3, 24'd6, 1'b1);
    send_item(OP_TWIST, 1'b0, 1'b0);
    repeat (8) send_item(OP_TICK, 1'b0, 1'b0);
    send_item(OP_TWIST, 1'b1, 1'b0);
    repeat (2) send_item(OP_TICK, 1'b1, 1'b1);
    send_item(OP_TWIST, 1'b1, 1'b1);
    send_item(OP_TWIST, 1'b0, 1'b0);
    send_item(OP_PUSH, 1'b0, 1'b0);
    repeat (2) send_item(OP_TICK, 1'b0, 1'b0);
    // A second push while still pressed restarts the release count.
    send_item(OP_PUSH, 1'b1, 1'b0);
    repeat (3) send_item(OP_TICK, 1'b0, 1'b0);
    send_item(OP_PUSH, 1'b0, 1'b1);
    send_item(OP_NONE, 1'b0, 1'b1);
    repeat (6) send_item(OP_TICK, 1'b0, 1'b0);
  endtask

  task automatic test_zero_durations();
    set_durations('0, '0, '0);
    send_item(OP_TWIST, 1'b1, 1'b0);
    send_item(OP_PUSH, 1'b0, 1'b0);
    repeat (2) send_item(OP_TICK, 1'b0, 1'b0);
    send_item(OP_PUSH, 1'b1, 1'b1);
    repeat (4) send_item(OP_TICK, 1'b1, 1'b0);
  endtask

  task automatic test_max_durations();
    set_durations({TickW{1'b1}}, {TickW{1'b1}}, {TickW{1'b1}});
    send_item(OP_TWIST, 1'b0, 1'b1);
    send_item(OP_PUSH, 1'b0, 1'b1);
    send_item(OP_PUSH, 1'b1, 1'b0);
    repeat (3) send_item(OP_TICK, 1'b1, 1'b1);
    send_item(OP_NONE, 1'b1, 1'b0);
  endtask

  // Several same-direction twists pile up steps, then one tick per step
  // until the count is exhausted.
  task automatic test_step_accumulate();
    set_durations(24'd1, 24'd1, 24'd1);
    burst = 1'b1;
    repeat (10) send_item(OP_TWIST, 1'b1, 1'b0);
    repeat (44) send_item(OP_TICK, 1'b0, 1'b0);
    burst = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned sel;
    for (int round = 0; round < 5; round++) begin
      set_durations(TickW'($urandom_range(1, 6)), TickW'($urandom_range(1, 25)),
                    TickW'($urandom_range(1, 60)));
      burst = (round == 2);
      for (int n = 0; n < 90; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60)
          send_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else if (sel < 78)
          send_item(OP_TWIST, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else if (sel < 92)
          send_item(OP_PUSH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          send_item(OP_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    eff_step        = StepTicksReset;
    eff_press       = PressTicksReset;
    eff_long        = LongPressTicksReset;
    m_phase         = 2'd0;
    m_dir           = DIR_NONE;
    m_steps         = '0;
    m_step_timer    = '0;
    m_release_timer = '0;
    m_button        = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_levels();
    test_directed_sequence();
    test_zero_durations();
    test_max_durations();
    test_step_accumulate();
    test_random_traffic();
    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_levels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: a fresh random stall before every result beat, except in burst mode.
  initial begin
    int unsigned pause;
    wait (rst == 1'b0);
    forever begin
      pause = burst ? 0 : $urandom_range(0, 8);
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat a=%b b=%b button=%b busy=%b",
                                  out_a, out_b, button_level, busy_res));
      end else begin
        want = expected_levels.pop_front();
        check_field("out_a", out_a, want.a);
        check_field("out_b", out_b, want.b);
        check_field("button_level", button_level, want.button);
        check_field("busy_res", busy_res, want.busy);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
